/* src/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

  localparam int ADDR_W            = 24;
  localparam int DEF_MAX_BLOCKS    = 64;
  localparam int DEF_HEADER_BYTES  = 32;
  localparam int DEF_ALIGN_BYTES   = 16;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 24'd1048576;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  // One table entry as it moves through the cell chain.
  typedef struct packed {
    logic              used;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } blk_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic              live;   // cell index is below block_count
    logic              hit;    // a match already happened upstream
  } tok_t;

endpackage

/* src/first_fit_heap_allocator_unit.sv */
// Top level of the first-fit heap allocator.
// Usage: requests arrive on in_valid/in_ready with in_command (0 allocate,
// 1 free), in_req_size and in_free_addr. One response per request leaves on
// out_valid/out_ready with out_payload_addr and out_status (0 ok, 1 out of
// space, 2 unknown address).
// The table is a chain of MAX_BLOCKS cells; each holds one entry and passes
// a search token to its neighbor, so lookup is resolved across the chain.
// Allocate and plain free pass through the search, decision and output states
// from accept to response. A free that reaches the heap top also trims
// trailing unused entries, one per cycle, then sets the heap top. One request
// is in flight at a time; a new request is taken only in the cycle after the
// previous response has been accepted, so a stalled receiver holds the input.
// heap_limit is written over the cfg_ APB port at address 0.
// Reset empties the table (block count and heap top to zero) and restores
// heap_limit to 1 MiB; no clearing pass is needed.
module first_fit_heap_allocator_unit #(
  parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
  parameter int ALIGN_BYTES  = ffha_pkg::DEF_ALIGN_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [23:0] in_req_size,
  input  logic [23:0] in_free_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_payload_addr,
  output logic [1:0]  out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ffha_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SRCH  = 5'b00010,
    S_DEC   = 5'b00100,
    S_TRIM  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [23:0] limit_r;
  logic [CW-1:0] cnt_r;
  logic [23:0] top_r;
  logic cmd_r;
  logic [24:0] need_r;
  logic [23:0] addr_r;
  logic ovalid_r;
  logic [23:0] oaddr_r;
  logic [1:0] ostat_r;
  logic hit_r;
  logic [IW-1:0] hidx_r;
  blk_t hent_r;
  blk_t last_r;

  // Config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {8'd0, limit_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= HEAP_LIMIT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      limit_r <= cfg_pwdata[23:0];
    end
  end

  // Size rounding
  logic [24:0] rounded;
  always_comb begin
    logic [24:0] r;
    r = 25'({1'b0, in_req_size} % ALIGN_BYTES);
    rounded = (r == 25'd0) ? {1'b0, in_req_size}
                           : 25'({1'b0, in_req_size} + 25'(ALIGN_BYTES) - r);
  end

  // Cell chain
  tok_t tok [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0] mvec;
  blk_t q [MAX_BLOCKS];
  blk_t wdata;
  logic do_app, do_set, do_clr;
  logic [IW-1:0] widx;

  assign tok[0] = '{live: 1'b1, hit: 1'b0};

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    tok_t ti;
    assign ti = '{live: (CW'(g) < cnt_r), hit: tok[g].hit};
    ffha_cell u_cell (
      .clk(clk), .we(do_app && widx == IW'(g)), .wdata(wdata),
      .set_used(do_set && hidx_r == IW'(g)),
      .clr_used(do_clr && hidx_r == IW'(g)),
      .is_free_cmd(cmd_r), .need(need_r), .addr(addr_r),
      .tok_in(ti), .tok_out(tok[g+1]), .match(mvec[g]), .q(q[g]));
  end

  // Encode the single hit position
  logic [IW-1:0] menc;
  always_comb begin
    menc = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (mvec[k]) menc = IW'(k);
    end
  end

  logic [25:0] base_w, newtop_w;
  assign base_w   = 26'(top_r) + 26'(HEADER_BYTES);
  assign newtop_w = base_w + 26'(need_r);
  logic [24:0] hend;
  assign hend = 25'(hent_r.start) + 25'(hent_r.size);
  logic [IW-1:0] lidx;
  assign lidx = IW'(cnt_r - CW'(1));

  assign widx  = cnt_r[IW-1:0] & {IW{cnt_r < CW'(MAX_BLOCKS)}};
  assign wdata = '{used: 1'b1, start: base_w[23:0], size: need_r[23:0]};
  assign in_ready = (state_r == S_IDLE) && !ovalid_r;

  always_comb begin
    state_nxt = state_r;
    do_app = 1'b0; do_set = 1'b0; do_clr = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = S_SRCH;
      S_SRCH: state_nxt = S_DEC;
      S_DEC: begin
        if (cmd_r == CMD_ALLOC) begin
          if (hit_r) do_set = 1'b1;
          else if (cnt_r < CW'(MAX_BLOCKS) && newtop_w <= 26'(limit_r)) do_app = 1'b1;
          state_nxt = S_OUT;
        end else begin
          if (hit_r) begin
            do_clr = 1'b1;
            state_nxt = ({1'b0, top_r} == hend) ? S_TRIM : S_OUT;
          end else state_nxt = S_OUT;
        end
      end
      S_TRIM: if (cnt_r == '0 || last_r.used) state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Response fields decided in the decision state
  logic [23:0] dec_addr;
  logic [1:0]  dec_stat;
  always_comb begin
    dec_addr = '0;
    dec_stat = ST_OK;
    if (cmd_r == CMD_ALLOC) begin
      if (hit_r) dec_addr = hent_r.start;
      else if (do_app) dec_addr = base_w[23:0];
      else dec_stat = ST_NOSPACE;
    end else if (!hit_r) dec_stat = ST_BADADDR;
  end

  // Last entry as seen after the clear, and the one below it while trimming
  blk_t last_dec, last_trim;
  always_comb begin
    last_dec = q[lidx];
    if (lidx == hidx_r) last_dec.used = 1'b0;
    last_trim = q[IW'(cnt_r - CW'(2))];
    if (cnt_r == CW'(1)) last_trim.used = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      top_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          cmd_r  <= in_command;
          need_r <= rounded;
          addr_r <= in_free_addr;
        end
        S_SRCH: begin
          hit_r  <= tok[MAX_BLOCKS].hit;
          hidx_r <= menc;
          hent_r <= q[menc];
        end
        S_DEC: begin
          oaddr_r <= dec_addr;
          ostat_r <= dec_stat;
          if (do_app) begin
            cnt_r <= cnt_r + CW'(1);
            top_r <= newtop_w[23:0];
          end
          last_r <= last_dec;
        end
        S_TRIM: begin
          if (cnt_r == '0) top_r <= '0;
          else if (last_r.used) top_r <= 24'(last_r.start + last_r.size);
          else begin
            cnt_r  <= cnt_r - CW'(1);
            last_r <= last_trim;
          end
        end
        S_OUT: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid        = ovalid_r;
  assign out_payload_addr = oaddr_r;
  assign out_status       = ostat_r;
endmodule

/* src/ffha_cell.sv */
// One table cell: holds an entry and checks it against the broadcast request.
module ffha_cell (
  input  logic                 clk,
  input  logic                 we,
  input  ffha_pkg::blk_t       wdata,
  input  logic                 set_used,
  input  logic                 clr_used,
  input  logic                 is_free_cmd,
  input  logic [24:0]          need,
  input  logic [23:0]          addr,
  input  ffha_pkg::tok_t       tok_in,
  output ffha_pkg::tok_t       tok_out,
  output logic                 match,
  output ffha_pkg::blk_t       q
);
  import ffha_pkg::*;

  blk_t ent_r;
  logic cand;

  // Entry storage; used flag is updated by grant/free strobes.
  always_ff @(posedge clk) begin
    if (we) begin
      ent_r <= wdata;
    end else if (set_used) begin
      ent_r.used <= 1'b1;
    end else if (clr_used) begin
      ent_r.used <= 1'b0;
    end
  end

  // Candidate test, then first-hit priority along the chain.
  assign cand = is_free_cmd ? (ent_r.start == addr)
                            : (!ent_r.used && ({1'b0, ent_r.size} >= need));
  assign match        = tok_in.live && !tok_in.hit && cand;
  assign tok_out.live = tok_in.live;
  assign tok_out.hit  = tok_in.hit || match;
  assign q            = ent_r;
endmodule

/* src/ffha_checker.sv */
// Port-level checks for the allocator, bound to the top level.
module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_payload_addr,
  input logic [1:0]  out_status
);
  import ffha_pkg::*;

  // Status code is never the unused value
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  // Errors carry a zero address
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_payload_addr == '0)
    else $error("error with address");
  // No new request while a response waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while busy");
  // Stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("response dropped");
endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_payload_addr(out_payload_addr), .out_status(out_status));

/* bench/ffha_checker.sv */
// Response checker for the first-fit heap allocator: tracks the block table and compares.
module ffha_scoreboard #(
  parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
  parameter int ALIGN_BYTES  = ffha_pkg::DEF_ALIGN_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  logic [23:0] in_req_size,
  input  logic [23:0] in_free_addr,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [23:0] out_payload_addr,
  input  logic [1:0]  out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending
);
  import ffha_pkg::*;

  typedef struct packed {
    logic [23:0] addr;
    logic [1:0]  status;
  } grant_t;

  // Shadow copy of the allocator state
  logic [23:0] limit_q;
  logic [23:0] tbl_start [MAX_BLOCKS];
  logic [23:0] tbl_size  [MAX_BLOCKS];
  logic        tbl_used  [MAX_BLOCKS];
  int          tbl_count;
  logic [23:0] top_q;
  grant_t      grants_q [$];

  assign pending = grants_q.size();

  task automatic report(input string what);
    $display("mismatch: %s at %0t", what, $realtime);
    fail_count++;
  endtask

  // Allocate: first fit, else append at the heap top
  function automatic grant_t grant_alloc(input logic [23:0] req);
    logic [31:0] sz;
    logic [31:0] base;
    logic [31:0] new_top;
    sz = {8'd0, req};
    if (sz % ALIGN_BYTES != 0) sz = sz + ALIGN_BYTES - sz % ALIGN_BYTES;
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_used[i] && {8'd0, tbl_size[i]} >= sz) begin
        tbl_used[i] = 1'b1;
        return '{tbl_start[i], ST_OK};
      end
    end
    base = {8'd0, top_q} + HEADER_BYTES;
    new_top = base + sz;
    if (tbl_count >= MAX_BLOCKS || new_top > {8'd0, limit_q}) return '{24'd0, ST_NOSPACE};
    tbl_start[tbl_count] = base[23:0];
    tbl_size[tbl_count] = sz[23:0];
    tbl_used[tbl_count] = 1'b1;
    tbl_count++;
    top_q = new_top[23:0];
    return '{base[23:0], ST_OK};
  endfunction

  // Free: lowest matching entry, then trim trailing unused blocks
  function automatic grant_t release_block(input logic [23:0] addr);
    int hit;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] == addr) begin
        hit = i;
        break;
      end
    end
    if (hit < 0) return '{24'd0, ST_BADADDR};
    tbl_used[hit] = 1'b0;
    if ({8'd0, tbl_start[hit]} + {8'd0, tbl_size[hit]} == {8'd0, top_q}) begin
      while (tbl_count > 0 && !tbl_used[tbl_count-1]) tbl_count--;
      if (tbl_count == 0) top_q = '0;
      else top_q = tbl_start[tbl_count-1] + tbl_size[tbl_count-1];
    end
    return '{24'd0, ST_OK};
  endfunction

  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst_n) begin
      limit_q <= HEAP_LIMIT_RST;
      tbl_count = 0;
      top_q = '0;
      grants_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
        limit_q <= cfg_pwdata[23:0];
      if (in_valid && in_ready)
        grants_q.push_back(in_command == CMD_FREE ? release_block(in_free_addr)
                                                  : grant_alloc(in_req_size));
      if (out_valid && out_ready) begin
        if (grants_q.size() == 0) begin
          report("response with no request pending");
        end else begin
          exp_g = grants_q.pop_front();
          if (out_payload_addr !== exp_g.addr)
            report($sformatf("payload_addr %h expected %h", out_payload_addr, exp_g.addr));
          if (out_status !== exp_g.status)
            report($sformatf("status %0d expected %0d", out_status, exp_g.status));
        end
      end
    end
  end

endmodule

/* bench/testbench.sv */
// Stimulus and verdict for the first-fit heap allocator.
module testbench;
  import ffha_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int MAX_BLOCKS_WAIT = DEF_MAX_BLOCKS + 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [23:0] in_req_size;
  logic [23:0] in_free_addr;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] out_payload_addr;
  logic [1:0]  out_status;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;
  int          quiet_cycles;
  bit          steady;
  logic [23:0] granted [$];

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  first_fit_heap_allocator_unit dut (.*);

  ffha_scoreboard chk (.*);

  // Response backpressure
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // Watchdog on acceptance activity
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[first_fit_heap_allocator_unit] ERROR");
        $finish;
      end
    end
  end

  // Keep granted addresses so frees can hit live blocks
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_status == ST_OK && out_payload_addr != 0)
      granted.push_back(out_payload_addr);
  end

  task automatic send_request(input logic cmd, input logic [23:0] sz, input logic [23:0] addr);
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(0, 99) < 25);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_req_size <= sz;
    in_free_addr <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (MAX_BLOCKS_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(input logic [23:0] lim);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'd0;
    cfg_pwdata <= {8'd0, lim};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_free_addr;
    int k;
    if (granted.size() == 0 || $urandom_range(0, 9) == 0) return 24'($urandom);
    k = $urandom_range(0, granted.size() - 1);
    pick_free_addr = granted[k];
    if ($urandom_range(0, 3) != 0) granted.delete(k);
  endfunction

  task automatic random_phase(input int n, input int big_pct);
    logic [23:0] sz;
    for (int i = 0; i < n; i++) begin
      steady = (i >= n / 2 && i < n / 2 + 80);
      if ($urandom_range(0, 99) < 45) begin
        send_request(CMD_FREE, 24'($urandom), pick_free_addr());
      end else begin
        if ($urandom_range(0, 99) < big_pct) sz = 24'($urandom);
        else sz = 24'($urandom_range(0, 600));
        send_request(CMD_ALLOC, sz, 24'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_ALLOC;
    in_req_size = '0;
    in_free_addr = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    steady = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero size, rounding, extremes, frees of every kind
    send_request(CMD_ALLOC, 24'd0, 24'hFFFFFF);
    send_request(CMD_ALLOC, 24'd1, 24'd0);
    send_request(CMD_ALLOC, 24'd16, 24'd0);
    send_request(CMD_ALLOC, 24'd17, 24'd0);
    send_request(CMD_ALLOC, 24'hFFFFFF, 24'd0);
    send_request(CMD_ALLOC, 24'hFFFFF1, 24'd0);
    send_request(CMD_FREE, 24'hFFFFFF, 24'd32);
    send_request(CMD_FREE, 24'd0, 24'd32);
    send_request(CMD_ALLOC, 24'd0, 24'd0);
    send_request(CMD_FREE, 24'd0, 24'd12345);
    send_request(CMD_FREE, 24'd0, 24'd0);
    send_request(CMD_FREE, 24'd0, 24'hFFFFFF);
    send_request(CMD_FREE, 24'd0, 24'd96);
    send_request(CMD_FREE, 24'd0, 24'd144);
    send_request(CMD_FREE, 24'd0, 24'd64);
    send_request(CMD_FREE, 24'd0, 24'd32);
    send_request(CMD_ALLOC, 24'd8, 24'd0);
    drain();

    // Limit zero: every append fails, heap stays empty above
    write_limit(24'd0);
    send_request(CMD_ALLOC, 24'd0, 24'd0);
    send_request(CMD_ALLOC, 24'd5, 24'd0);
    drain();
    write_limit(24'hFFFFFF);
    send_request(CMD_ALLOC, 24'h7FFFF0, 24'd0);
    send_request(CMD_ALLOC, 24'h7FFFF0, 24'd0);
    drain();

    // Random phases across several limits, table fills in the small ones
    granted.delete();
    write_limit(HEAP_LIMIT_RST);
    random_phase(500, 2);
    drain();
    write_limit(24'd4000);
    random_phase(400, 3);
    drain();
    write_limit(24'd40);
    random_phase(150, 2);
    drain();
    write_limit(24'hFFFFFF);
    random_phase(550, 10);
    drain();

    if (fail_count == 0) begin
      $display("[first_fit_heap_allocator_unit] OK");
    end else begin
      $display("[first_fit_heap_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ffha_pkg.sv
src/ffha_cell.sv
src/first_fit_heap_allocator_unit.sv
src/ffha_checker.sv
bench/ffha_checker.sv
bench/testbench.sv
